// File: rtl/float_sqrt_newton_defines.svh
// Assertion macros for the float square root RTL.
`ifndef FLOAT_SQRT_NEWTON_DEFINES_SVH
`define FLOAT_SQRT_NEWTON_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FSN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsn: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FSN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsn: next-cycle check failed");

`endif

// File: rtl/fsn_pkg.sv
// Package: shared types, constants and rounding helper for the float square root.
package fsn_pkg;

  localparam int FSN_NEWTON_STEPS = 4;
  localparam int DIV_BITS         = 54;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] PINF_BITS = 32'h7F80_0000;

  // significand of 1/sqrt(2) truncated to 53 bits, hidden bit included
  localparam logic [52:0] INV_SQRT2_MANT = 53'h16A09E667F3BCC;

  typedef logic signed [9:0] fsn_exp_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] op;
    logic [23:0] ma;
    fsn_exp_t    ea;
    logic [52:0] mx;
    fsn_exp_t    ex;
  } fsn_item_t;

  typedef struct packed {
    logic [52:0] m;
    fsn_exp_t    e;
  } fsn_dbl_t;

  function automatic fsn_dbl_t round53(input logic [52:0] m, input logic g, input logic s,
                                       input fsn_exp_t e);
    fsn_dbl_t   r;
    logic [53:0] sum;
    sum = {1'b0, m} + {53'd0, g & (s | m[0])};
    if (sum[53]) begin
      r.m = sum[53:1];
      r.e = e + 10'sd1;
    end else begin
      r.m = sum[52:0];
      r.e = e;
    end
    return r;
  endfunction

endpackage

// File: rtl/fsn_newton_step.sv
// One pipelined Newton step: x = 0.5 * (x + A / x) in double precision.
module fsn_newton_step import fsn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  fsn_item_t in_item,
  output fsn_item_t out_item
);

  typedef struct packed {
    fsn_item_t   it;
    logic [53:0] rem;
    logic [53:0] qb;
    fsn_exp_t    eq;
  } div_stage_t;

  typedef struct packed {
    fsn_item_t it;
    fsn_dbl_t  q;
  } quo_stage_t;

  typedef struct packed {
    fsn_item_t   it;
    logic [52:0] mb;
    fsn_exp_t    eb;
    logic [55:0] al;
  } aln_stage_t;

  typedef struct packed {
    fsn_item_t   it;
    logic [56:0] s;
    fsn_exp_t    eb;
  } sum_stage_t;

  div_stage_t div_r   [0:DIV_BITS];
  div_stage_t div_nxt [0:DIV_BITS];
  quo_stage_t quo_r, quo_nxt;
  aln_stage_t aln_r, aln_nxt;
  sum_stage_t sum_r, sum_nxt;
  fsn_item_t  out_r, out_nxt;

  // divider setup: bring A/x ratio into [1,2)
  always_comb begin
    logic [53:0] ma54;
    logic [53:0] mx54;
    ma54 = {1'b0, in_item.ma, 29'd0};
    mx54 = {1'b0, in_item.mx};
    div_nxt[0].it = in_item;
    div_nxt[0].qb = '0;
    if (ma54 >= mx54) begin
      div_nxt[0].rem = ma54;
      div_nxt[0].eq  = in_item.ea - in_item.ex;
    end else begin
      div_nxt[0].rem = {in_item.ma, 29'd0, 1'b0};
      div_nxt[0].eq  = in_item.ea - in_item.ex - 10'sd1;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= DIV_BITS; k++) begin : g_div
      always_comb begin
        logic [53:0] mx54;
        logic        ge;
        logic [53:0] r1;
        mx54 = {1'b0, div_r[k-1].it.mx};
        ge   = (div_r[k-1].rem >= mx54);
        r1   = ge ? (div_r[k-1].rem - mx54) : div_r[k-1].rem;
        div_nxt[k]     = div_r[k-1];
        div_nxt[k].rem = {r1[52:0], 1'b0};
        div_nxt[k].qb  = {div_r[k-1].qb[52:0], ge};
      end
    end
    for (k = 0; k <= DIV_BITS; k++) begin : g_div_reg
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          div_r[k].it.vld <= 1'b0;
        end else if (adv) begin
          div_r[k] <= div_nxt[k];
        end
      end
    end
  endgenerate

  // quotient rounding
  always_comb begin
    quo_nxt.it = div_r[DIV_BITS].it;
    quo_nxt.q  = round53(div_r[DIV_BITS].qb[53:1], div_r[DIV_BITS].qb[0],
                         |div_r[DIV_BITS].rem, div_r[DIV_BITS].eq);
  end

  // alignment of the smaller addend
  always_comb begin
    logic [52:0] ms;
    fsn_exp_t    es;
    fsn_exp_t    d;
    logic [5:0]  dsh;
    logic [55:0] small56;
    logic        lost;
    aln_nxt.it = quo_r.it;
    if (quo_r.q.e > quo_r.it.ex) begin
      aln_nxt.mb = quo_r.q.m;
      aln_nxt.eb = quo_r.q.e;
      ms         = quo_r.it.mx;
      es         = quo_r.it.ex;
    end else begin
      aln_nxt.mb = quo_r.it.mx;
      aln_nxt.eb = quo_r.it.ex;
      ms         = quo_r.q.m;
      es         = quo_r.q.e;
    end
    d          = aln_nxt.eb - es;
    dsh        = (d > 10'sd56) ? 6'd56 : d[5:0];
    small56    = {ms, 3'b000};
    lost       = |(small56 & ~({56{1'b1}} << dsh));
    aln_nxt.al = (small56 >> dsh) | {55'd0, lost};
  end

  always_comb begin
    sum_nxt.it = aln_r.it;
    sum_nxt.eb = aln_r.eb;
    sum_nxt.s  = {1'b0, aln_r.mb, 3'b000} + {1'b0, aln_r.al};
  end

  // round the sum and halve it
  always_comb begin
    fsn_dbl_t r;
    if (sum_r.s[56]) begin
      r = round53(sum_r.s[56:4], sum_r.s[3], |sum_r.s[2:0], sum_r.eb + 10'sd1);
    end else begin
      r = round53(sum_r.s[55:3], sum_r.s[2], |sum_r.s[1:0], sum_r.eb);
    end
    out_nxt    = sum_r.it;
    out_nxt.mx = r.m;
    out_nxt.ex = r.e - 10'sd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_r.it.vld <= 1'b0;
      aln_r.it.vld <= 1'b0;
      sum_r.it.vld <= 1'b0;
      out_r.vld    <= 1'b0;
    end else if (adv) begin
      quo_r <= quo_nxt;
      aln_r <= aln_nxt;
      sum_r <= sum_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

// File: rtl/float_sqrt_newton.sv
// Pipeline: e1, e2, st, NEWTON_STEPS Newton steps (four by default), out register.
// One operand per cycle unless the output stalls; each step has a radix-2 divider.
// A stalled output freezes the whole pipe; nothing is dropped or repeated.
// rst_n is synchronous, active low, and clears every stage valid bit.
// Top level: single-precision square root by a fixed number of Newton steps.
module float_sqrt_newton import fsn_pkg::*; #(
  parameter int NEWTON_STEPS = FSN_NEWTON_STEPS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_root_bits,
  output logic        out_invalid
);

`include "float_sqrt_newton_defines.svh"

  typedef struct packed {
    logic        vld;
    logic [31:0] op;
    logic [23:0] ma;
    fsn_exp_t    ea;
    logic [23:0] em;
    fsn_exp_t    half;
    logic        odd;
    logic [49:0] ph;
    logic [50:0] pl;
  } est1_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] op;
    logic [23:0] ma;
    fsn_exp_t    ea;
    logic [23:0] em;
    fsn_exp_t    half;
    logic        odd;
    logic [76:0] p;
  } est2_t;

  localparam logic [25:0] C_HI = INV_SQRT2_MANT[52:27];
  localparam logic [26:0] C_LO = INV_SQRT2_MANT[26:0];

  logic      adv;
  est1_t     e1_r, e1_nxt;
  est2_t     e2_r, e2_nxt;
  fsn_item_t st_r, st_nxt;
  fsn_item_t chain [0:NEWTON_STEPS];
  logic        out_valid_r;
  logic [31:0] out_root_r, out_root_nxt;
  logic        out_invalid_r, out_invalid_nxt;

  function automatic logic [4:0] lead_pos(input logic [22:0] m);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) p = i[4:0];
    end
    return p;
  endfunction

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // decode, first estimate, partial products of the odd-exponent correction
  always_comb begin
    logic [7:0]  ef;
    logic [22:0] mf;
    logic [4:0]  p;
    ef = in_operand_bits[30:23];
    mf = in_operand_bits[22:0];
    p  = lead_pos(mf);
    e1_nxt.vld = in_valid;
    e1_nxt.op  = in_operand_bits;
    if (ef != 8'd0) begin
      e1_nxt.ma = {1'b1, mf};
      e1_nxt.ea = $signed({2'b00, ef}) - 10'sd127;
    end else begin
      e1_nxt.ma = {1'b0, mf} << (5'd23 - p);
      e1_nxt.ea = $signed({5'd0, p}) - 10'sd149;
    end
    e1_nxt.em   = {1'b1, 1'b0, mf[22:1]};
    e1_nxt.half = ($signed({2'b00, ef}) - 10'sd126) >>> 1;
    e1_nxt.odd  = ~ef[0];
    e1_nxt.ph   = e1_nxt.em * C_HI;
    e1_nxt.pl   = e1_nxt.em * C_LO;
  end

  always_comb begin
    e2_nxt.vld  = e1_r.vld;
    e2_nxt.op   = e1_r.op;
    e2_nxt.ma   = e1_r.ma;
    e2_nxt.ea   = e1_r.ea;
    e2_nxt.em   = e1_r.em;
    e2_nxt.half = e1_r.half;
    e2_nxt.odd  = e1_r.odd;
    e2_nxt.p    = {e1_r.ph, 27'd0} + {26'd0, e1_r.pl};
  end

  always_comb begin
    fsn_dbl_t r;
    if (e2_r.p[76]) begin
      r = round53(e2_r.p[76:24], e2_r.p[23], |e2_r.p[22:0], e2_r.half);
    end else begin
      r = round53(e2_r.p[75:23], e2_r.p[22], |e2_r.p[21:0], e2_r.half - 10'sd1);
    end
    st_nxt.vld = e2_r.vld;
    st_nxt.op  = e2_r.op;
    st_nxt.ma  = e2_r.ma;
    st_nxt.ea  = e2_r.ea;
    if (e2_r.odd) begin
      st_nxt.mx = r.m;
      st_nxt.ex = r.e;
    end else begin
      st_nxt.mx = {e2_r.em, 29'd0};
      st_nxt.ex = e2_r.half;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r.vld <= 1'b0;
      e2_r.vld <= 1'b0;
      st_r.vld <= 1'b0;
    end else if (adv) begin
      e1_r <= e1_nxt;
      e2_r <= e2_nxt;
      st_r <= st_nxt;
    end
  end

  assign chain[0] = st_r;

  genvar i;
  generate
    for (i = 0; i < NEWTON_STEPS; i++) begin : g_step
      fsn_newton_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_item  (chain[i]),
        .out_item (chain[i+1])
      );
    end
  endgenerate

  // round to single and resolve special operands
  always_comb begin
    fsn_item_t   it;
    logic [24:0] s25;
    logic [9:0]  fe;
    logic [22:0] fm;
    logic [7:0]  ef;
    logic [22:0] mf;
    it  = chain[NEWTON_STEPS];
    ef  = it.op[30:23];
    mf  = it.op[22:0];
    s25 = {1'b0, it.mx[52:29]} + {24'd0, it.mx[28] & ((|it.mx[27:0]) | it.mx[29])};
    if (s25[24]) begin
      fe = it.ex + 10'sd128;
      fm = s25[23:1];
    end else begin
      fe = it.ex + 10'sd127;
      fm = s25[22:0];
    end
    out_invalid_nxt = 1'b0;
    if (ef == 8'hFF && mf != 23'd0) begin
      out_root_nxt = it.op;
    end else if (it.op[30:0] == 31'd0) begin
      out_root_nxt = 32'd0;
    end else if (it.op[31]) begin
      out_root_nxt    = QNAN_BITS;
      out_invalid_nxt = 1'b1;
    end else if (ef == 8'hFF) begin
      out_root_nxt = PINF_BITS;
    end else begin
      out_root_nxt = {1'b0, fe[7:0], fm};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[NEWTON_STEPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_root_r    <= out_root_nxt;
      out_invalid_r <= out_invalid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_root_bits = out_root_r;
  assign out_invalid   = out_invalid_r;

  `FSN_ASSERT_NOW(a_invalid_is_qnan, out_valid_r && out_invalid_r, out_root_r == QNAN_BITS)
  `FSN_ASSERT_NEXT(a_stall_freezes_front, !adv, $stable(e1_r.vld) && $stable(st_r.vld))
  `FSN_ASSERT_NEXT(a_last_stage_reaches_out, adv && chain[NEWTON_STEPS].vld, out_valid_r)

endmodule
